@@ sv/apsd_pkg.sv @@
package apsd_pkg;

  // Fixed field widths and defaults
  localparam int SPEED_BITS         = 32;
  localparam int LEVEL_BITS_DEF     = 11;
  localparam int TIME_BITS_DEF      = 32;
  localparam int CFG_ADDR_BITS      = 2;
  localparam int CFG_DATA_BITS      = 32;
  localparam int MODE_BITS          = 2;
  localparam logic [SPEED_BITS-1:0] SPEED_CONSTANT_RST = 32'd3117691;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_TRIGGER     = 2'd0,
    CFG_SILENCE     = 2'd1,
    CFG_CONTINUOUS  = 2'd2,
    CFG_SPEED_CONST = 2'd3
  } cfg_addr_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LEVEL  = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_DISARM = 2'd2
  } mode_e;

  // Measurement phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_TRACK = 3'b100
  } phase_e;

  // Sequencer state
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_e;

  typedef struct packed {
    logic accept;     // take the input word, update tracking
    logic div_start;  // start the speed division
    logic load;       // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic result;     // current input word closes an event
    logic div_done;   // quotient ready
    logic out_free;   // output register can take a word
  } ctrl_sts_t;

endpackage

@@ sv/apsd_div.sv @@
module apsd_div import apsd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SPEED_BITS-1:0] dividend_i,
  input  logic [TIME_BITS-1:0]  divisor_i,
  output logic                  done_o,
  output logic [SPEED_BITS-1:0] quotient_o
);

  localparam int CNT_W = $clog2(SPEED_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPEED_BITS - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SPEED_BITS-1:0] quo_q, quo_d;
  logic [TIME_BITS-1:0]  rem_q, rem_d;
  logic [TIME_BITS-1:0]  dvs_q, dvs_d;

  logic [TIME_BITS:0]    shifted;
  logic [TIME_BITS:0]    diff;
  logic                  ge;

  // Restoring division, one quotient bit per cycle; divisor zero gives all ones
  assign shifted = {rem_q, quo_q[SPEED_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[SPEED_BITS-2:0], ge};
      rem_d = ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ sv/apsd_dp.sv @@
module apsd_dp import apsd_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic [MODE_BITS-1:0]     mode_i,
  input  logic [LEVEL_BITS-1:0]    level_i,
  input  logic [TIME_BITS-1:0]     time_i,
  input  ctrl_cmd_t                cmd_i,
  output ctrl_sts_t                sts_o,
  input  logic                     m_ready_i,
  output logic                     m_valid_o,
  output logic [SPEED_BITS-1:0]    speed_o,
  output logic [LEVEL_BITS-1:0]    peak_o,
  output logic [LEVEL_BITS-1:0]    half_o,
  output logic [TIME_BITS-1:0]     delta_o,
  output logic                     zero_o
);

  // Configuration
  logic [LEVEL_BITS-1:0] trig_q, sil_q;
  logic                  cont_q;
  logic [SPEED_BITS-1:0] const_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q  <= '0;
      sil_q   <= '0;
      cont_q  <= 1'b0;
      const_q <= SPEED_CONSTANT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_TRIGGER:     trig_q  <= cfg_wdata_i[LEVEL_BITS-1:0];
        CFG_SILENCE:     sil_q   <= cfg_wdata_i[LEVEL_BITS-1:0];
        CFG_CONTINUOUS:  cont_q  <= cfg_wdata_i[0];
        CFG_SPEED_CONST: const_q <= cfg_wdata_i[SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Event tracking
  phase_e                ph_q, ph_d;
  logic [LEVEL_BITS-1:0] pk_q, pk_d, hl_q, hl_d;
  logic [TIME_BITS-1:0]  pkt_q, pkt_d, ht_q, ht_d;
  logic                  hs_q, hs_d;
  logic                  result;

  // Snapshot of a closed event
  logic [LEVEL_BITS-1:0] res_pk_q, res_hl_q;
  logic [TIME_BITS-1:0]  res_dt_q;
  logic [LEVEL_BITS-1:0] res_pk_d, res_hl_d;
  logic [TIME_BITS-1:0]  res_dt_d;

  logic                  new_peak, half_hit;

  assign new_peak = level_i > pk_q;
  assign half_hit = !new_peak && !hs_q && (level_i < (pk_q >> 1));

  always_comb begin
    ph_d     = ph_q;
    pk_d     = pk_q;
    pkt_d    = pkt_q;
    hl_d     = hl_q;
    ht_d     = ht_q;
    hs_d     = hs_q;
    result   = 1'b0;
    res_pk_d = res_pk_q;
    res_hl_d = res_hl_q;
    res_dt_d = res_dt_q;
    unique case (mode_i)
      MODE_ARM, MODE_DISARM: begin
        pk_d  = '0;
        pkt_d = '0;
        hl_d  = '0;
        ht_d  = '0;
        hs_d  = 1'b0;
        ph_d  = (mode_i == MODE_ARM) ? PH_WAIT : PH_IDLE;
      end
      MODE_LEVEL: begin
        unique case (ph_q)
          PH_WAIT: begin
            if (level_i > trig_q) begin
              pk_d  = level_i;
              pkt_d = time_i;
              hs_d  = 1'b0;
              ph_d  = PH_TRACK;
            end
          end
          PH_TRACK: begin
            if (new_peak) begin
              pk_d  = level_i;
              pkt_d = time_i;
              hs_d  = 1'b0;
            end else if (half_hit) begin
              hs_d = 1'b1;
              hl_d = level_i;
              ht_d = time_i;
            end
            // a new peak clears the record, so it never ends the event
            if (hs_d && (level_i < sil_q)) begin
              result   = 1'b1;
              res_pk_d = pk_d;
              res_hl_d = hl_d;
              res_dt_d = ht_d - pkt_d;
              pk_d     = '0;
              pkt_d    = '0;
              hl_d     = '0;
              ht_d     = '0;
              hs_d     = 1'b0;
              ph_d     = cont_q ? PH_WAIT : PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      pk_q  <= '0;
      pkt_q <= '0;
      hl_q  <= '0;
      ht_q  <= '0;
      hs_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      ph_q  <= ph_d;
      pk_q  <= pk_d;
      pkt_q <= pkt_d;
      hl_q  <= hl_d;
      ht_q  <= ht_d;
      hs_q  <= hs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_pk_q <= res_pk_d;
      res_hl_q <= res_hl_d;
      res_dt_q <= res_dt_d;
    end
  end

  // Speed division
  logic                  div_done;
  logic [SPEED_BITS-1:0] quotient;

  apsd_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (const_q),
    .divisor_i  (res_dt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output register
  logic                  m_valid_q;
  logic [SPEED_BITS-1:0] speed_q;
  logic [LEVEL_BITS-1:0] peak_q, half_q;
  logic [TIME_BITS-1:0]  delta_q;
  logic                  zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      speed_q <= quotient;
      peak_q  <= res_pk_q;
      half_q  <= res_hl_q;
      delta_q <= res_dt_q;
      zero_q  <= (res_dt_q == '0);
    end
  end

  assign sts_o.result   = result;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign speed_o   = speed_q;
  assign peak_o    = peak_q;
  assign half_o    = half_q;
  assign delta_o   = delta_q;
  assign zero_o    = zero_q;

endmodule

@@ sv/apsd_ctrl.sv @@
module apsd_ctrl import apsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.result) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // wait for the previous result to drain
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/acoustic_passby_speed_detector_top.sv @@
// Pass-by speed detector. Each input word is a level window (tuser MODE_LEVEL) or an
// arm/disarm event. A word that does not close an event is accepted at once and the
// next can follow immediately. A word that closes an event starts a bit-serial 32-bit
// division (speed_constant / delta_ms): the input stays stalled through a start state,
// 32 divide steps, a wait for the divider's done flag and a load into the output
// register, and longer while an earlier result still waits downstream. Results sit in
// an output register, so the input side runs on while a result waits to be taken.
module acoustic_passby_speed_detector_top import apsd_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // level, time_ms
  input  logic [((LEVEL_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // mode
  input  logic [MODE_BITS-1:0]     s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // speed_centi_kmh, peak_out, half_out, delta_ms
  output logic [((SPEED_BITS+2*LEVEL_BITS+TIME_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // zero_delta
  output logic                     m_axis_tuser_o
);

  localparam int OUT_W = ((SPEED_BITS + 2*LEVEL_BITS + TIME_BITS + 7) / 8) * 8;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  logic [SPEED_BITS-1:0] speed;
  logic [LEVEL_BITS-1:0] peak, half;
  logic [TIME_BITS-1:0]  delta;

  apsd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  apsd_dp #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (s_axis_tuser_i),
    .level_i     (s_axis_tdata_i[LEVEL_BITS-1:0]),
    .time_i      (s_axis_tdata_i[LEVEL_BITS +: TIME_BITS]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .speed_o     (speed),
    .peak_o      (peak),
    .half_o      (half),
    .delta_o     (delta),
    .zero_o      (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OUT_W'({delta, half, peak, speed});

endmodule
